// ===== rtl/core/bfa_pkg.sv =====
// Shared constants, command codes and control/status types of the block allocator.
package bfa_pkg;

	localparam int MEM_UNITS  = 64;
	localparam int MAX_BLOCKS = 32;
	localparam int UNIT_W     = $clog2(MEM_UNITS);
	localparam int LEN_W      = $clog2(MEM_UNITS + 1);
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int SLACK_W    = 3;
	localparam int SIZE_W     = 7;
	localparam int OP_W       = 2;
	localparam int STS_W      = 2;

	localparam logic [SLACK_W-1:0] SLACK_RESET = 3'd2;

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// result status codes
	localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
	localparam logic [STS_W-1:0] STS_TOO_BIG = 2'd1;
	localparam logic [STS_W-1:0] STS_NO_FIT  = 2'd2;

	// datapath commands
	localparam int CMD_W = 5;
	localparam logic [CMD_W-1:0] CMD_NOP    = 5'd0;
	localparam logic [CMD_W-1:0] CMD_INIT   = 5'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 5'd2;
	localparam logic [CMD_W-1:0] CMD_DISP   = 5'd3;
	localparam logic [CMD_W-1:0] CMD_RD_IDX = 5'd4;
	localparam logic [CMD_W-1:0] CMD_A_CHK  = 5'd5;
	localparam logic [CMD_W-1:0] CMD_REM_RD = 5'd6;
	localparam logic [CMD_W-1:0] CMD_REM_WR = 5'd7;
	localparam logic [CMD_W-1:0] CMD_F_CM   = 5'd8;
	localparam logic [CMD_W-1:0] CMD_MERGE  = 5'd9;
	localparam logic [CMD_W-1:0] CMD_SEL1   = 5'd10;
	localparam logic [CMD_W-1:0] CMD_SEL2   = 5'd11;
	localparam logic [CMD_W-1:0] CMD_I_CHK  = 5'd12;
	localparam logic [CMD_W-1:0] CMD_S_SET  = 5'd13;
	localparam logic [CMD_W-1:0] CMD_S_RD   = 5'd14;
	localparam logic [CMD_W-1:0] CMD_S_WR   = 5'd15;
	localparam logic [CMD_W-1:0] CMD_S_PUT  = 5'd16;
	localparam logic [CMD_W-1:0] CMD_EMIT   = 5'd17;

	typedef struct packed {
		logic [CMD_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic op_alloc;
		logic op_free;
		logic op_clear;
		logic big_req;
		logic tbl_empty;
		logic tbl_full;
		logic hit;
		logic whole;
		logic idx_last;
		logic free_ok;
		logic need_scan;
		logic lf;
		logic rf;
		logic rem_last;
		logic i_more;
		logic lt;
		logic sh_more;
	} sts_t;

	// bit mask of units st .. st+len-1, clipped to the memory
	function automatic logic [MEM_UNITS-1:0] range_mask(input logic [UNIT_W-1:0] st,
			input logic [LEN_W-1:0] len);
		logic [MEM_UNITS-1:0] m;
		logic [LEN_W:0] top;
		top = (LEN_W+1)'(st) + (LEN_W+1)'(len);
		for (int k = 0; k < MEM_UNITS; k++) begin
			m[k] = ((LEN_W+1)'(k) >= (LEN_W+1)'(st)) && ((LEN_W+1)'(k) < top);
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/bfa_dp.sv =====
// Datapath of the block allocator: bitmap, free-block table memory, scan and shift registers.
module bfa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfa_pkg::cmd_t                 cmd,
	output bfa_pkg::sts_t                 sts,
	input  logic                          slack_units_we,
	input  logic [bfa_pkg::SLACK_W-1:0]   slack_units,
	input  logic [bfa_pkg::OP_W-1:0]      op,
	input  logic [bfa_pkg::SIZE_W-1:0]    size_units,
	input  logic [bfa_pkg::UNIT_W-1:0]    start_unit,
	output logic [bfa_pkg::STS_W-1:0]     status,
	output logic [bfa_pkg::UNIT_W-1:0]    grant_start,
	output logic [bfa_pkg::SIZE_W-1:0]    grant_units
);

	localparam int UW = bfa_pkg::UNIT_W;
	localparam int LW = bfa_pkg::LEN_W;
	localparam int IW = bfa_pkg::IDX_W;
	localparam int CW = bfa_pkg::CNT_W;
	localparam int SW = bfa_pkg::SIZE_W;

	// free-block table memory
	logic [UW-1:0] st_mem  [bfa_pkg::MAX_BLOCKS];
	logic [LW-1:0] len_mem [bfa_pkg::MAX_BLOCKS];

	logic [bfa_pkg::SLACK_W-1:0] slack_q;
	logic [bfa_pkg::OP_W-1:0]    op_q;
	logic [SW-1:0]               size_q;
	logic [UW-1:0]               s_q;
	logic [LW-1:0]               n_q;
	logic [bfa_pkg::MEM_UNITS-1:0] map_q;
	logic [CW-1:0]               cnt_q, idx_q, j_q;
	logic                        lf_q, rf_q;
	logic [IW-1:0]               li_q, ri_q;
	logic [UW-1:0]               lst_q, ms_q;
	logic [LW-1:0]               llen_q, rlen_q, ml_q;
	logic [UW-1:0]               rd_st_q;
	logic [LW-1:0]               rd_len_q;
	logic [bfa_pkg::STS_W-1:0]   res_sts_q;
	logic [UW-1:0]               res_gs_q;
	logic [LW-1:0]               res_gu_q;
	logic [bfa_pkg::STS_W-1:0]   out_sts_q;
	logic [UW-1:0]               out_gs_q;
	logic [LW-1:0]               out_gu_q;

	logic [LW-1:0] room, n_clip, end_u, left, gu;
	logic [bfa_pkg::MEM_UNITS-1:0] free_mask;
	logic          need_l, need_r, hit, whole;
	logic          we;
	logic [IW-1:0] wa, ra;
	logic [UW-1:0] wst;
	logic [LW-1:0] wlen;
	logic [CW-1:0] idx_inc, j_inc, j_dec;

	// input clipping and region checks
	always_comb begin
		room      = LW'(bfa_pkg::MEM_UNITS) - LW'(start_unit);
		n_clip    = (LW'(size_units) > room) ? room : LW'(size_units);
		end_u     = LW'(s_q) + n_q;
		free_mask = bfa_pkg::range_mask(s_q, n_q);
		need_l    = (s_q != '0) && !map_q[s_q - UW'(1)];
		need_r    = (end_u < LW'(bfa_pkg::MEM_UNITS)) && !map_q[end_u[UW-1:0]];
		hit       = LW'(rd_len_q) >= LW'(size_q);
		left      = rd_len_q - LW'(size_q);
		whole     = left <= LW'(slack_q);
		gu        = whole ? rd_len_q : LW'(size_q);
		idx_inc   = idx_q + CW'(1);
		j_inc     = j_q + CW'(1);
		j_dec     = j_q - CW'(1);
	end

	// status to the controller
	always_comb begin
		sts.op_alloc  = (op_q == bfa_pkg::OP_ALLOC);
		sts.op_free   = (op_q == bfa_pkg::OP_FREE);
		sts.op_clear  = (op_q == bfa_pkg::OP_CLEAR);
		sts.big_req   = size_q > SW'(bfa_pkg::MEM_UNITS);
		sts.tbl_empty = (cnt_q == '0);
		sts.tbl_full  = (cnt_q >= CW'(bfa_pkg::MAX_BLOCKS));
		sts.hit       = hit;
		sts.whole     = whole;
		sts.idx_last  = (idx_q + CW'(1)) >= cnt_q;
		sts.free_ok   = (n_q != '0) && ((map_q & free_mask) == free_mask);
		sts.need_scan = need_l || need_r;
		sts.lf        = lf_q;
		sts.rf        = rf_q;
		sts.rem_last  = (j_q + CW'(1)) >= cnt_q;
		sts.i_more    = idx_q < cnt_q;
		sts.lt        = rd_len_q < ml_q;
		sts.sh_more   = j_q > idx_q;
	end

	// table write and read ports
	always_comb begin
		we   = 1'b0;
		wa   = idx_q[IW-1:0];
		wst  = rd_st_q;
		wlen = rd_len_q;
		ra   = idx_q[IW-1:0];
		case (cmd.code)
			bfa_pkg::CMD_INIT: begin
				we   = 1'b1;
				wa   = '0;
				wst  = '0;
				wlen = LW'(bfa_pkg::MEM_UNITS);
			end
			bfa_pkg::CMD_A_CHK: begin
				we   = hit && !whole;
				wst  = rd_st_q + size_q[UW-1:0];
				wlen = left;
			end
			bfa_pkg::CMD_REM_RD: ra = j_inc[IW-1:0];
			bfa_pkg::CMD_REM_WR: begin
				we = 1'b1;
				wa = j_q[IW-1:0];
			end
			bfa_pkg::CMD_S_RD: ra = j_dec[IW-1:0];
			bfa_pkg::CMD_S_WR: begin
				we = 1'b1;
				wa = j_q[IW-1:0];
			end
			bfa_pkg::CMD_S_PUT: begin
				we   = 1'b1;
				wst  = ms_q;
				wlen = ml_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			st_mem[wa]  <= wst;
			len_mem[wa] <= wlen;
		end
		rd_st_q  <= st_mem[ra];
		rd_len_q <= len_mem[ra];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slack_q <= bfa_pkg::SLACK_RESET;
		end else if (slack_units_we) begin
			slack_q <= slack_units;
		end
	end

	// table count and bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CW'(1);
			map_q <= '0;
		end else begin
			case (cmd.code)
				bfa_pkg::CMD_INIT: begin
					cnt_q <= CW'(1);
					map_q <= '0;
				end
				bfa_pkg::CMD_A_CHK: begin
					if (hit) begin
						map_q <= map_q | bfa_pkg::range_mask(rd_st_q, gu);
					end
				end
				bfa_pkg::CMD_REM_RD: begin
					if (sts.rem_last) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				bfa_pkg::CMD_S_PUT: begin
					cnt_q <= cnt_q + CW'(1);
					map_q <= map_q & ~free_mask;
				end
				default: ;
			endcase
		end
	end

	// item registers, scan indexes, merge data and results
	always_ff @(posedge clk) begin
		case (cmd.code)
			bfa_pkg::CMD_LOAD: begin
				op_q      <= op;
				size_q    <= size_units;
				s_q       <= start_unit;
				n_q       <= n_clip;
				idx_q     <= '0;
				lf_q      <= 1'b0;
				rf_q      <= 1'b0;
				res_sts_q <= bfa_pkg::STS_DONE;
				res_gs_q  <= '0;
				res_gu_q  <= '0;
			end
			bfa_pkg::CMD_DISP: begin
				if (sts.op_alloc && sts.big_req) begin
					res_sts_q <= bfa_pkg::STS_TOO_BIG;
				end else if (sts.op_alloc && sts.tbl_empty) begin
					res_sts_q <= bfa_pkg::STS_NO_FIT;
				end
			end
			bfa_pkg::CMD_A_CHK: begin
				if (hit) begin
					res_gs_q <= rd_st_q;
					res_gu_q <= gu;
					j_q      <= idx_q;
				end else if (sts.idx_last) begin
					res_sts_q <= bfa_pkg::STS_NO_FIT;
				end else begin
					idx_q <= idx_inc;
				end
			end
			bfa_pkg::CMD_REM_WR: j_q <= j_inc;
			bfa_pkg::CMD_F_CM: begin
				if (need_l && !lf_q && (LW'(rd_st_q) + rd_len_q == LW'(s_q))) begin
					lf_q   <= 1'b1;
					li_q   <= idx_q[IW-1:0];
					lst_q  <= rd_st_q;
					llen_q <= rd_len_q;
				end
				if (need_r && !rf_q && (LW'(rd_st_q) == end_u)) begin
					rf_q   <= 1'b1;
					ri_q   <= idx_q[IW-1:0];
					rlen_q <= rd_len_q;
				end
				idx_q <= idx_inc;
			end
			bfa_pkg::CMD_MERGE: begin
				ms_q  <= lf_q ? lst_q : s_q;
				ml_q  <= n_q + (lf_q ? llen_q : '0) + (rf_q ? rlen_q : '0);
				idx_q <= '0;
			end
			bfa_pkg::CMD_SEL1: begin
				if (lf_q && rf_q) begin
					j_q <= CW'((li_q > ri_q) ? li_q : ri_q);
				end else begin
					j_q <= CW'(lf_q ? li_q : ri_q);
				end
			end
			bfa_pkg::CMD_SEL2: j_q <= CW'((li_q > ri_q) ? ri_q : li_q);
			bfa_pkg::CMD_I_CHK: begin
				if (sts.lt) begin
					idx_q <= idx_inc;
				end
			end
			bfa_pkg::CMD_S_SET: j_q <= cnt_q;
			bfa_pkg::CMD_S_WR: j_q <= j_dec;
			bfa_pkg::CMD_EMIT: begin
				out_sts_q <= res_sts_q;
				out_gs_q  <= res_gs_q;
				out_gu_q  <= res_gu_q;
			end
			default: ;
		endcase
	end

	assign status      = out_sts_q;
	assign grant_start = out_gs_q;
	assign grant_units = SW'(out_gu_q);

endmodule

// ===== rtl/core/bfa_ctrl.sv =====
// Controller state machine of the block allocator: sequences scans, shifts and result beats.
module bfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  bfa_pkg::sts_t sts,
	output bfa_pkg::cmd_t cmd
);

	localparam logic [4:0] S_INIT   = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_DISP   = 5'd2;
	localparam logic [4:0] S_A_RD   = 5'd3;
	localparam logic [4:0] S_A_CHK  = 5'd4;
	localparam logic [4:0] S_REM_RD = 5'd5;
	localparam logic [4:0] S_REM_WR = 5'd6;
	localparam logic [4:0] S_F_RD   = 5'd7;
	localparam logic [4:0] S_F_CM   = 5'd8;
	localparam logic [4:0] S_F_DEC  = 5'd9;
	localparam logic [4:0] S_MERGE  = 5'd10;
	localparam logic [4:0] S_SEL1   = 5'd11;
	localparam logic [4:0] S_SEL2   = 5'd12;
	localparam logic [4:0] S_I_RD   = 5'd13;
	localparam logic [4:0] S_I_CHK  = 5'd14;
	localparam logic [4:0] S_SH_SET = 5'd15;
	localparam logic [4:0] S_SH_RD  = 5'd16;
	localparam logic [4:0] S_SH_WR  = 5'd17;
	localparam logic [4:0] S_SH_PUT = 5'd18;
	localparam logic [4:0] S_CLR    = 5'd19;
	localparam logic [4:0] S_FIN    = 5'd20;

	// what follows a removal: finish alloc, next removal, or insert
	localparam logic [1:0] PH_ALLOC = 2'd0;
	localparam logic [1:0] PH_REM1  = 2'd1;
	localparam logic [1:0] PH_REM2  = 2'd2;

	logic [4:0] state_q, state_d;
	logic [1:0] ph_q, ph_d;
	logic       out_valid_q;
	logic       emit;

	always_comb begin
		state_d  = state_q;
		ph_d     = ph_q;
		cmd.code = bfa_pkg::CMD_NOP;
		emit     = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.code = bfa_pkg::CMD_INIT;
				state_d  = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = bfa_pkg::CMD_LOAD;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				cmd.code = bfa_pkg::CMD_DISP;
				if (sts.op_alloc) begin
					ph_d    = PH_ALLOC;
					state_d = (sts.big_req || sts.tbl_empty) ? S_FIN : S_A_RD;
				end else if (sts.op_free) begin
					if (!sts.free_ok) begin
						state_d = S_FIN;
					end else if (sts.need_scan && !sts.tbl_empty) begin
						state_d = S_F_RD;
					end else begin
						state_d = S_F_DEC;
					end
				end else if (sts.op_clear) begin
					state_d = S_CLR;
				end else begin
					state_d = S_FIN;
				end
			end
			// allocate: first-fit scan over the length-ordered table
			S_A_RD: begin
				cmd.code = bfa_pkg::CMD_RD_IDX;
				state_d  = S_A_CHK;
			end
			S_A_CHK: begin
				cmd.code = bfa_pkg::CMD_A_CHK;
				if (sts.hit) begin
					state_d = sts.whole ? S_REM_RD : S_FIN;
				end else begin
					state_d = sts.idx_last ? S_FIN : S_A_RD;
				end
			end
			// entry removal: shift the tail down one slot
			S_REM_RD: begin
				cmd.code = bfa_pkg::CMD_REM_RD;
				if (!sts.rem_last) begin
					state_d = S_REM_WR;
				end else if (ph_q == PH_ALLOC) begin
					state_d = S_FIN;
				end else if (ph_q == PH_REM1 && sts.lf && sts.rf) begin
					state_d = S_SEL2;
				end else begin
					state_d = S_I_RD;
				end
			end
			S_REM_WR: begin
				cmd.code = bfa_pkg::CMD_REM_WR;
				state_d  = S_REM_RD;
			end
			// free: look for left and right neighbors
			S_F_RD: begin
				cmd.code = bfa_pkg::CMD_RD_IDX;
				state_d  = S_F_CM;
			end
			S_F_CM: begin
				cmd.code = bfa_pkg::CMD_F_CM;
				state_d  = sts.idx_last ? S_F_DEC : S_F_RD;
			end
			S_F_DEC: begin
				if (!sts.lf && !sts.rf && sts.tbl_full) begin
					state_d = S_FIN;
				end else begin
					state_d = S_MERGE;
				end
			end
			S_MERGE: begin
				cmd.code = bfa_pkg::CMD_MERGE;
				state_d  = (sts.lf || sts.rf) ? S_SEL1 : S_I_RD;
			end
			S_SEL1: begin
				cmd.code = bfa_pkg::CMD_SEL1;
				ph_d     = PH_REM1;
				state_d  = S_REM_RD;
			end
			S_SEL2: begin
				cmd.code = bfa_pkg::CMD_SEL2;
				ph_d     = PH_REM2;
				state_d  = S_REM_RD;
			end
			// insert: find position by length, then shift the tail up
			S_I_RD: begin
				cmd.code = bfa_pkg::CMD_RD_IDX;
				state_d  = sts.i_more ? S_I_CHK : S_SH_SET;
			end
			S_I_CHK: begin
				cmd.code = bfa_pkg::CMD_I_CHK;
				state_d  = sts.lt ? S_I_RD : S_SH_SET;
			end
			S_SH_SET: begin
				cmd.code = bfa_pkg::CMD_S_SET;
				state_d  = S_SH_RD;
			end
			S_SH_RD: begin
				cmd.code = bfa_pkg::CMD_S_RD;
				state_d  = sts.sh_more ? S_SH_WR : S_SH_PUT;
			end
			S_SH_WR: begin
				cmd.code = bfa_pkg::CMD_S_WR;
				state_d  = S_SH_RD;
			end
			S_SH_PUT: begin
				cmd.code = bfa_pkg::CMD_S_PUT;
				state_d  = S_FIN;
			end
			S_CLR: begin
				cmd.code = bfa_pkg::CMD_INIT;
				state_d  = S_FIN;
			end
			// hand the result to the output register once it is free
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.code = bfa_pkg::CMD_EMIT;
					emit     = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			ph_q        <= PH_ALLOC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/best_fit_block_allocator.sv =====
// Top level of the best-fit block allocator over a 64-unit memory.
//
// Input channel (in_valid/in_ready) carries one beat per operation: op, size_units,
// start_unit. Output channel (out_valid/out_ready) returns one beat per operation:
// status, grant_start, grant_units. slack_units is written with slack_units_we; the user
// must write it only while the block is idle, as the block itself does not enforce it.
// One operation is in flight at a time; in_ready is high only when the sequencer is
// idle. Operation time is set by the free-block table memory, which has one read
// port: each table step reads an entry and then acts on it.
// A finished result waits in the output register; a new operation is accepted while
// it waits, and its own result holds until the receiver takes the earlier beat.
// Reset restores one free block covering all memory; after reset the sequencer writes
// that entry into the table in its init state, before the first beat is accepted.
module best_fit_block_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        slack_units_we,
	input  logic [bfa_pkg::SLACK_W-1:0] slack_units,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bfa_pkg::OP_W-1:0]    op,
	input  logic [bfa_pkg::SIZE_W-1:0]  size_units,
	input  logic [bfa_pkg::UNIT_W-1:0]  start_unit,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bfa_pkg::STS_W-1:0]   status,
	output logic [bfa_pkg::UNIT_W-1:0]  grant_start,
	output logic [bfa_pkg::SIZE_W-1:0]  grant_units
);

	bfa_pkg::cmd_t cmd;
	bfa_pkg::sts_t sts;

	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.slack_units_we (slack_units_we),
		.slack_units    (slack_units),
		.op             (op),
		.size_units     (size_units),
		.start_unit     (start_unit),
		.status         (status),
		.grant_start    (grant_start),
		.grant_units    (grant_units)
	);

endmodule

// ===== rtl/core/bfa_checker.sv =====
// Port-level checker of the block allocator and its bind to the top level.
module bfa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [bfa_pkg::STS_W-1:0]   status,
	input logic [bfa_pkg::UNIT_W-1:0]  grant_start,
	input logic [bfa_pkg::SIZE_W-1:0]  grant_units
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(grant_start)
			&& $stable(grant_units))
		else $error("result beat changed while stalled");

	// failures grant nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != bfa_pkg::STS_DONE) |-> grant_units == '0 && grant_start == '0)
		else $error("failed operation reports a grant");

	// a grant stays inside memory
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (8'(grant_start) + 8'(grant_units)) <= 8'(bfa_pkg::MEM_UNITS))
		else $error("grant runs past end of memory");

	// status code 3 is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == bfa_pkg::STS_DONE || status == bfa_pkg::STS_TOO_BIG
			|| status == bfa_pkg::STS_NO_FIT)
		else $error("undefined status code");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.grant_start (grant_start),
	.grant_units (grant_units)
);
